### hw/rtl/bmqs_pkg.sv
// shared constants and codes for the balanced multi-queue store
package bmqs_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int MAX_QUEUES_DEF = 8;

  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int QIDX_W   = 3;
  localparam int NQ_W     = 4;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

### hw/rtl/bmqs_pick.sv
// occupancy arbiter: lowest-index argmin for inserts, argmax for removes
module bmqs_pick
  import bmqs_pkg::*;
#(
  parameter int MAX_QUEUES = MAX_QUEUES_DEF,
  parameter int OW         = 6,
  parameter int QW         = 3
) (
  input  logic [OW-1:0]         occ [MAX_QUEUES],
  input  logic [MAX_QUEUES-1:0] en,
  input  logic                  action,
  output logic [QW-1:0]         best
);

  localparam int P = 1 << QW;

  logic [OW-1:0] lv_occ [QW+1][P];
  logic [QW-1:0] lv_idx [QW+1][P];
  logic          lv_en  [QW+1][P];

  // tournament tree, the left entry always holds the lower index so ties keep it
  always_comb begin
    logic take_right;
    take_right = 1'b0;
    for (int l = 0; l <= QW; l++) begin
      for (int i = 0; i < P; i++) begin
        lv_occ[l][i] = '0;
        lv_idx[l][i] = '0;
        lv_en[l][i]  = 1'b0;
      end
    end
    for (int i = 0; i < P; i++) begin
      if (i < MAX_QUEUES) begin
        lv_occ[0][i] = occ[i];
        lv_en[0][i]  = en[i];
      end
      lv_idx[0][i] = QW'(i);
    end
    for (int l = 0; l < QW; l++) begin
      for (int j = 0; j < P; j++) begin
        if (j < (P >> (l + 1))) begin
          if (!lv_en[l][2*j+1]) begin
            take_right = 1'b0;
          end else if (!lv_en[l][2*j]) begin
            take_right = 1'b1;
          end else if (action == ACT_REMOVE) begin
            take_right = lv_occ[l][2*j+1] > lv_occ[l][2*j];
          end else begin
            take_right = lv_occ[l][2*j+1] < lv_occ[l][2*j];
          end
          lv_occ[l+1][j] = take_right ? lv_occ[l][2*j+1] : lv_occ[l][2*j];
          lv_idx[l+1][j] = take_right ? lv_idx[l][2*j+1] : lv_idx[l][2*j];
          lv_en[l+1][j]  = lv_en[l][2*j] | lv_en[l][2*j+1];
        end
      end
    end
  end

  assign best = lv_idx[QW][0];

endmodule

### hw/rtl/balanced_multi_queue_store_core.sv
// top level: shared word store split into equal linear queues, balanced by occupancy
//
// Input channel: in_valid / in_stall carry one request (action, data_in).
//   action insert puts data_in into the least occupied queue, action remove
//   takes the oldest word of the most occupied queue; ties pick the lowest queue.
// Output channel: out_valid / out_stall carry one result per request
//   (status, queue_index, data_out). data_out is zero unless a remove succeeded.
// Configuration: cfg_we writes cfg_wdata as the queue count and clears every
//   queue's pointers; write it only while no request is in flight.
// Flow: an accepted request is arbitrated first (pointers update, the store is
//   read), then its result loads the output register. No request is taken
//   during arbitration; the next one is accepted as the previous result loads.
// The result register holds while out_stall is high; one further request may
//   finish its arbitration behind it, then in_stall stays high until it drains.
// Reset (rst, synchronous): one queue, all pointers zero, no result pending.
//   Store contents are not cleared; only words already written are ever read.
module balanced_multi_queue_store_core
  import bmqs_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int MAX_QUEUES = MAX_QUEUES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [NQ_W-1:0]            cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic signed [DATA_W-1:0]   data_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [QIDX_W-1:0]          queue_index,
  output logic signed [DATA_W-1:0]   data_out
);

  localparam int OW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int NW = $clog2(MAX_QUEUES + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ARB  = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;

  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [NW-1:0]     act_n;
  logic [OW-1:0]     seg_size;
  logic [OW-1:0]     head [MAX_QUEUES];
  logic [OW-1:0]     tail [MAX_QUEUES];
  logic [OW-1:0]     occ  [MAX_QUEUES];
  logic [OW-1:0]     size_tab [MAX_QUEUES];
  logic [MAX_QUEUES-1:0] q_en;

  logic              req_action;
  logic [DATA_W-1:0] req_data;
  logic [STATUS_W-1:0] res_status;
  logic [QW-1:0]     res_idx;
  logic              res_rd;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  logic              in_acc;
  logic              out_load;
  logic [QW-1:0]     best;
  logic [OW-1:0]     sel_head;
  logic [OW-1:0]     sel_tail;
  logic              is_rem;
  logic              ins_ok;
  logic              rem_ok;
  logic [OW-1:0]     off;
  logic [QW+OW-1:0]  addr_full;
  logic [AW-1:0]     mem_addr;
  logic [NQ_W:0]     cfg_ext;
  logic [NW-1:0]     n_eff;
  logic [QW+2:0]     idx_ext;

  // segment size for each queue count, settled at elaboration
  for (genvar g = 0; g < MAX_QUEUES; g++) begin : g_size
    localparam int SZ = DEPTH / (g + 1);
    assign size_tab[g] = OW'(SZ);
    assign occ[g]      = tail[g] - head[g];
    assign q_en[g]     = NW'(g) < act_n;
  end

  bmqs_pick #(
    .MAX_QUEUES (MAX_QUEUES),
    .OW         (OW),
    .QW         (QW)
  ) u_pick (
    .occ    (occ),
    .en     (q_en),
    .action (req_action),
    .best   (best)
  );

  assign out_load = (phase == PH_FIN) && (!out_valid || !out_stall);
  assign in_stall = (phase == PH_ARB) || ((phase == PH_FIN) && !out_load);
  assign in_acc   = in_valid && !in_stall;

  assign sel_head  = head[best];
  assign sel_tail  = tail[best];
  assign is_rem    = req_action == ACT_REMOVE;
  assign ins_ok    = !is_rem && (sel_tail < seg_size);
  assign rem_ok    = is_rem && (sel_tail != sel_head);
  assign off       = is_rem ? sel_head : sel_tail;
  // best * size + offset stays below DEPTH for an active queue
  assign addr_full = ({{OW{1'b0}}, best} * {{QW{1'b0}}, seg_size}) + (QW+OW)'(off);
  assign mem_addr  = addr_full[AW-1:0];

  assign cfg_ext = {1'b0, cfg_wdata};
  always_comb begin
    if (cfg_wdata == '0) begin
      n_eff = NW'(1);
    end else if (cfg_ext > (NQ_W+1)'(MAX_QUEUES)) begin
      n_eff = NW'(MAX_QUEUES);
    end else begin
      n_eff = NW'(cfg_wdata);
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (in_acc) phase_next = PH_ARB;
      end
      PH_ARB: begin
        phase_next = PH_FIN;
      end
      PH_FIN: begin
        if (in_acc) phase_next = PH_ARB;
        else if (out_load) phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_n    <= NW'(1);
      seg_size <= size_tab[0];
    end else if (cfg_we) begin
      act_n    <= n_eff;
      seg_size <= size_tab[QW'(n_eff - NW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int q = 0; q < MAX_QUEUES; q++) begin
        head[q] <= '0;
        tail[q] <= '0;
      end
    end else if (phase == PH_ARB) begin
      if (ins_ok) tail[best] <= sel_tail + OW'(1);
      if (rem_ok) head[best] <= sel_head + OW'(1);
    end
  end

  // request capture and arbitration results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_action <= action;
      req_data   <= data_in;
    end
    if (phase == PH_ARB) begin
      res_idx <= best;
      res_rd  <= rem_ok;
      if (is_rem) res_status <= rem_ok ? ST_OK : ST_EMPTY;
      else res_status <= ins_ok ? ST_OK : ST_FULL;
    end
  end

  // shared store, one write or one read per arbitration cycle
  always_ff @(posedge clk) begin
    if ((phase == PH_ARB) && ins_ok) mem[mem_addr] <= req_data;
    if ((phase == PH_ARB) && rem_ok) rdata <= mem[mem_addr];
  end

  assign idx_ext = {3'b000, res_idx};

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      queue_index <= idx_ext[2:0];
      data_out    <= res_rd ? rdata : '0;
    end
  end

`ifndef SYNTHESIS
  a_arb_follows_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (phase == PH_ARB))
    else $error("arbitration did not follow an accepted request");

  a_no_accept_in_arb: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ARB) |-> in_stall)
    else $error("request accepted during arbitration");

  a_fin_after_arb: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ARB) |=> (phase == PH_FIN))
    else $error("result stage skipped");

  a_zero_data_unless_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (data_out == '0))
    else $error("nonzero data on a failed request");

  for (genvar g = 0; g < MAX_QUEUES; g++) begin : g_chk
    a_head_not_past_tail: assert property (@(posedge clk) disable iff (rst)
      tail[g] >= head[g])
      else $error("queue head passed its tail");
  end
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// testbench for the balanced multi-queue store: random requests checked against a predictor
module tb_top;
  import bmqs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEM_TARGET  = 1200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [QIDX_W-1:0]   qidx;
    logic [DATA_W-1:0]   data;
  } queue_result_t;

  // predicts status, chosen queue and removed word, and checks results in order
  class queue_balance_scoreboard;
    logic [DATA_W-1:0] words [DEPTH_DEF];
    int unsigned       head [MAX_QUEUES_DEF];
    int unsigned       tail [MAX_QUEUES_DEF];
    int unsigned       queue_count;
    queue_result_t     pending_results [$];
    int                failures;

    function new();
      foreach (words[i]) words[i] = '0;
      failures = 0;
      set_queue_count(NQ_W'(1));
    endfunction

    function void set_queue_count(logic [NQ_W-1:0] v);
      // zero acts as one, anything above the maximum acts as the maximum
      if (v == 0) queue_count = 1;
      else if (v > MAX_QUEUES_DEF) queue_count = MAX_QUEUES_DEF;
      else queue_count = v;
      foreach (head[q]) begin
        head[q] = 0;
        tail[q] = 0;
      end
    endfunction

    function void note_request(logic act, logic [DATA_W-1:0] d);
      int unsigned   seg;
      int unsigned   pick;
      int unsigned   occ;
      int unsigned   best_occ;
      queue_result_t r;
      seg = DEPTH_DEF / queue_count;
      pick = 0;
      best_occ = tail[0] - head[0];
      // strict compare keeps the lowest index on ties
      for (int q = 1; q < int'(queue_count); q++) begin
        occ = tail[q] - head[q];
        if ((act == ACT_INSERT) ? (occ < best_occ) : (occ > best_occ)) begin
          pick = q;
          best_occ = occ;
        end
      end
      r.status = ST_OK;
      r.qidx = pick[QIDX_W-1:0];
      r.data = '0;
      if (act == ACT_INSERT) begin
        if (tail[pick] >= seg) begin
          r.status = ST_FULL;
        end else begin
          words[pick * seg + tail[pick]] = d;
          tail[pick]++;
        end
      end else begin
        if (head[pick] >= tail[pick]) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = words[pick * seg + head[pick]];
          head[pick]++;
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [QIDX_W-1:0] qi,
                               logic [DATA_W-1:0] d);
      queue_result_t e;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("%0t: unexpected result status=%0d queue=%0d data=%h", $realtime,
                   st, qi, d);
      end else begin
        e = pending_results.pop_front();
        if (st !== e.status || qi !== e.qidx || d !== e.data) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("%0t: mismatch exp status=%0d queue=%0d data=%h got %0d %0d %h",
                     $realtime, e.status, e.qidx, e.data, st, qi, d);
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [NQ_W-1:0]          cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     action = ACT_INSERT;
  logic signed [DATA_W-1:0] data_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic [QIDX_W-1:0]        queue_index;
  logic signed [DATA_W-1:0] data_out;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int first_counts [6] = '{9, 0, 8, 1, 15, 2};
  int first_pcts [6] = '{100, 60, 75, 50, 90, 70};

  queue_balance_scoreboard qsb = new();

  balanced_multi_queue_store_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .data_in     (data_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .queue_index (queue_index),
    .data_out    (data_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL balanced_multi_queue_store_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) qsb.note_request(action, data_in);
      if (out_valid && !out_stall) qsb.check_result(status, queue_index, data_out);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        out_stall <= 1'b1;
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_request(input logic act, input logic [DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    data_in <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (qsb.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_queue_count(input logic [NQ_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    qsb.set_queue_count(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int  phase;
    int  len;
    int  pct;
    bit  hold_done;
    logic [NQ_W-1:0] nq;
    hold_done = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 29;
    recv_idle_pct = 72;

    // one queue after reset: empty remove, extreme words, drain past empty
    send_request(ACT_REMOVE, 32'h1234_5678);
    send_request(ACT_INSERT, 32'h7fff_ffff);
    send_request(ACT_INSERT, 32'h8000_0000);
    send_request(ACT_INSERT, 32'h0000_0000);
    send_request(ACT_INSERT, 32'hffff_ffff);
    send_request(ACT_INSERT, 32'h0000_0001);
    repeat (6) send_request(ACT_REMOVE, pick_word());

    // oversized count acts as eight queues: ties fill queues in index order
    write_queue_count(4'd15);
    repeat (9) send_request(ACT_INSERT, pick_word());
    repeat (2) send_request(ACT_REMOVE, pick_word());

    phase = 0;
    while (sent_count < ITEM_TARGET) begin
      if (sent_count < ITEM_TARGET / 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 72;
      end else if (sent_count < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase < 6) begin
        nq = NQ_W'(first_counts[phase]);
        pct = first_pcts[phase];
        len = 40;
      end else begin
        nq = NQ_W'($urandom_range(15));
        pct = 50 + 20 * $urandom_range(2);
        len = $urandom_range(20, 70);
      end
      write_queue_count(nq);
      if (!hold_done && sent_count >= 850) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      repeat (len)
        send_request(($urandom_range(99) < pct) ? ACT_INSERT : ACT_REMOVE, pick_word());
      phase++;
    end

    wait_drained();
    if (qsb.failures == 0 && qsb.pending_results.size() == 0)
      $display("PASS balanced_multi_queue_store_core");
    else
      $display("FAIL balanced_multi_queue_store_core");
    $finish;
  end

endmodule
